>>> src/edf_pkg.sv
// Shared types and constants of the EDF CPU/I/O scheduler.
package edf_pkg;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ID_W = 16;
  localparam int DL_W = 32;
  localparam int OP_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_TIME = 3'd0,
    OP_NEW = 3'd1,
    OP_DONE = 3'd2,
    OP_IO_REQ = 3'd3,
    OP_IO_DONE = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_INS_WRITE,
    ST_REM_SCAN,
    ST_REM_SHIFT,
    ST_CH_CPU,
    ST_CH_IO,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [31:0] event_time;
    logic [ID_W-1:0] task_id;
    logic [DL_W-1:0] deadline;
    logic batch_end;
    logic [ID_W-1:0] running_cpu_task;
    logic [ID_W-1:0] running_io_task;
  } in_beat_t;

  typedef struct packed {
    logic [ID_W-1:0] cpu_choice;
    logic [ID_W-1:0] io_choice;
    logic table_overflow;
  } out_beat_t;
endpackage

>>> src/edf_if.sv
// Valid/ready channel interfaces for the scheduler.
interface edf_in_if;
  logic valid;
  logic ready;
  edf_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface edf_out_if;
  logic valid;
  logic ready;
  edf_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/edf_cpu_io_scheduler_top.sv
// EDF scheduler: two deadline-sorted task tables held in synchronous RAMs.
// Each event walks its tables through a single RAM port pair; scans read one
// entry per cycle. An insert or remove scans for its slot and shifts the entries
// behind it; a decision then scans each table in turn, CPU table first.
// One item is in flight at a time; the result register frees the input side.
// Reset (synchronous, rst_n low) empties both tables and sets time to -1.
module edf_cpu_io_scheduler_top #(
  parameter int TABLE_DEPTH = edf_pkg::TABLE_DEPTH_DEF
) (
  input logic clk,
  input logic rst_n,
  edf_in_if.sink in_ch,
  edf_out_if.source out_ch
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = edf_pkg::ID_W + edf_pkg::DL_W;

  // Table 0 is ready, table 1 is wait.
  logic [EW-1:0] mem0 [TABLE_DEPTH];
  logic [EW-1:0] mem1 [TABLE_DEPTH];
  logic [EW-1:0] rd0_r, rd1_r, rd_sel;

  edf_pkg::state_t state_r, state_nxt;
  edf_pkg::in_beat_t beat_r, beat_nxt;
  logic [CW-1:0] cnt0_r, cnt0_nxt, cnt1_r, cnt1_nxt;
  logic [32:0] time_r, time_nxt;
  logic drop_r, drop_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic tab_r, tab_nxt;
  logic rem_pend_r, rem_pend_nxt;
  logic rd_pend_r, rd_pend_nxt;
  logic [edf_pkg::ID_W-1:0] cpu_r, cpu_nxt;
  logic [edf_pkg::ID_W-1:0] io_r, io_nxt;
  logic [edf_pkg::ID_W-1:0] first_r, first_nxt;
  logic oval_r, oval_nxt;
  edf_pkg::out_beat_t odata_r, odata_nxt;

  logic re;
  logic [AW-1:0] raddr;
  logic we;
  logic wtab;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (re) begin
      rd0_r <= mem0[raddr];
      rd1_r <= mem1[raddr];
    end
    if (we && !wtab) mem0[waddr] <= wdata;
    if (we && wtab) mem1[waddr] <= wdata;
  end

  assign rd_sel = tab_r ? rd1_r : rd0_r;
  wire [CW-1:0] cnt_cur = tab_r ? cnt1_r : cnt0_r;
  wire [edf_pkg::ID_W-1:0] rd_id = rd_sel[EW-1 -: edf_pkg::ID_W];
  wire [edf_pkg::DL_W-1:0] rd_dl = rd_sel[edf_pkg::DL_W-1:0];
  wire later = $signed({2'b00, rd_dl}) > $signed({time_r[32], time_r});

  assign in_ch.ready = (state_r == edf_pkg::ST_IDLE);
  assign out_ch.valid = oval_r;
  assign out_ch.data = odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= edf_pkg::ST_IDLE;
      cnt0_r <= '0;
      cnt1_r <= '0;
      time_r <= '1;
      drop_r <= 1'b0;
      oval_r <= 1'b0;
      rd_pend_r <= 1'b0;
      rem_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt0_r <= cnt0_nxt;
      cnt1_r <= cnt1_nxt;
      time_r <= time_nxt;
      drop_r <= drop_nxt;
      oval_r <= oval_nxt;
      rd_pend_r <= rd_pend_nxt;
      rem_pend_r <= rem_pend_nxt;
    end
    beat_r <= beat_nxt;
    pos_r <= pos_nxt;
    tab_r <= tab_nxt;
    cpu_r <= cpu_nxt;
    io_r <= io_nxt;
    first_r <= first_nxt;
    odata_r <= odata_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    beat_nxt = beat_r;
    cnt0_nxt = cnt0_r;
    cnt1_nxt = cnt1_r;
    time_nxt = time_r;
    drop_nxt = drop_r;
    pos_nxt = pos_r;
    tab_nxt = tab_r;
    rem_pend_nxt = rem_pend_r;
    rd_pend_nxt = 1'b0;
    cpu_nxt = cpu_r;
    io_nxt = io_r;
    first_nxt = first_r;
    oval_nxt = oval_r;
    odata_nxt = odata_r;
    re = 1'b0;
    raddr = pos_r[AW-1:0];
    we = 1'b0;
    wtab = tab_r;
    waddr = pos_r[AW-1:0];
    wdata = {beat_r.task_id, beat_r.deadline};

    if (oval_r && out_ch.ready) oval_nxt = 1'b0;

    unique case (state_r)
      edf_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          beat_nxt = in_ch.data;
          pos_nxt = '0;
          rem_pend_nxt = 1'b0;
          state_nxt = edf_pkg::ST_CH_CPU;
          case (in_ch.data.op)
            edf_pkg::OP_TIME: time_nxt = {1'b0, in_ch.data.event_time};
            edf_pkg::OP_NEW: begin
              tab_nxt = 1'b0;
              state_nxt = edf_pkg::ST_INS_SCAN;
            end
            edf_pkg::OP_DONE: begin
              tab_nxt = 1'b0;
              state_nxt = edf_pkg::ST_REM_SCAN;
            end
            edf_pkg::OP_IO_REQ: begin
              tab_nxt = 1'b1;
              rem_pend_nxt = 1'b1;
              state_nxt = edf_pkg::ST_INS_SCAN;
            end
            edf_pkg::OP_IO_DONE: begin
              tab_nxt = 1'b0;
              rem_pend_nxt = 1'b1;
              state_nxt = edf_pkg::ST_INS_SCAN;
            end
            default: ;
          endcase
          if (state_nxt == edf_pkg::ST_CH_CPU) tab_nxt = 1'b0;
        end
      end

      // Find the first entry with a later deadline; first_r records the slot.
      edf_pkg::ST_INS_SCAN: begin
        if (cnt_cur == CW'(TABLE_DEPTH)) begin
          drop_nxt = 1'b1;
          state_nxt = edf_pkg::ST_INS_WRITE;
          pos_nxt = '1;
        end else if (rd_pend_r) begin
          if (rd_dl > beat_r.deadline) begin
            pos_nxt = cnt_cur;
            state_nxt = edf_pkg::ST_INS_SHIFT;
          end else if (pos_r + 1'b1 == cnt_cur) begin
            pos_nxt = cnt_cur;
            state_nxt = edf_pkg::ST_INS_WRITE;
          end else begin
            pos_nxt = pos_r + 1'b1;
            re = 1'b1;
            raddr = pos_nxt[AW-1:0];
            rd_pend_nxt = 1'b1;
          end
        end else if (cnt_cur == '0) begin
          state_nxt = edf_pkg::ST_INS_WRITE;
        end else begin
          re = 1'b1;
          rd_pend_nxt = 1'b1;
        end
        // first_r keeps the slot index found during the scan.
        if (state_nxt == edf_pkg::ST_INS_SHIFT) first_nxt = edf_pkg::ID_W'(pos_r);
      end

      // Move entries up from the top down to the slot, each with a read and then a write.
      edf_pkg::ST_INS_SHIFT: begin
        if (pos_r == CW'(first_r)) begin
          state_nxt = edf_pkg::ST_INS_WRITE;
        end else if (!rd_pend_r) begin
          re = 1'b1;
          raddr = AW'(pos_r - 1'b1);
          rd_pend_nxt = 1'b1;
        end else begin
          we = 1'b1;
          wdata = rd_sel;
          pos_nxt = pos_r - 1'b1;
        end
      end

      edf_pkg::ST_INS_WRITE: begin
        if (pos_r != '1 || cnt_cur != CW'(TABLE_DEPTH)) begin
          we = 1'b1;
          if (tab_r) cnt1_nxt = cnt1_r + 1'b1;
          else cnt0_nxt = cnt0_r + 1'b1;
        end
        pos_nxt = '0;
        if (rem_pend_r) begin
          tab_nxt = !tab_r;
          state_nxt = edf_pkg::ST_REM_SCAN;
        end else begin
          tab_nxt = 1'b0;
          state_nxt = edf_pkg::ST_CH_CPU;
        end
        rem_pend_nxt = 1'b0;
      end

      edf_pkg::ST_REM_SCAN: begin
        if (rd_pend_r) begin
          if (rd_id == beat_r.task_id) begin
            state_nxt = edf_pkg::ST_REM_SHIFT;
          end else if (pos_r + 1'b1 >= cnt_cur) begin
            tab_nxt = 1'b0;
            pos_nxt = '0;
            state_nxt = edf_pkg::ST_CH_CPU;
          end else begin
            pos_nxt = pos_r + 1'b1;
            re = 1'b1;
            raddr = pos_nxt[AW-1:0];
            rd_pend_nxt = 1'b1;
          end
        end else if (cnt_cur == '0) begin
          tab_nxt = 1'b0;
          state_nxt = edf_pkg::ST_CH_CPU;
        end else begin
          re = 1'b1;
          rd_pend_nxt = 1'b1;
        end
      end

      // Pull entries down over the removed one.
      edf_pkg::ST_REM_SHIFT: begin
        if (pos_r + 1'b1 >= cnt_cur) begin
          if (tab_r) cnt1_nxt = cnt1_r - 1'b1;
          else cnt0_nxt = cnt0_r - 1'b1;
          tab_nxt = 1'b0;
          pos_nxt = '0;
          state_nxt = edf_pkg::ST_CH_CPU;
        end else if (!rd_pend_r) begin
          re = 1'b1;
          raddr = AW'(pos_r + 1'b1);
          rd_pend_nxt = 1'b1;
        end else begin
          we = 1'b1;
          wdata = rd_sel;
          pos_nxt = pos_r + 1'b1;
        end
      end

      edf_pkg::ST_CH_CPU, edf_pkg::ST_CH_IO: begin
        if (!beat_r.batch_end) begin
          state_nxt = edf_pkg::ST_IDLE;
        end else if (cnt_cur == '0 || (tab_r && beat_r.running_io_task != '0)) begin
          if (tab_r) begin
            io_nxt = beat_r.running_io_task;
            state_nxt = edf_pkg::ST_OUT;
          end else begin
            cpu_nxt = beat_r.running_cpu_task;
            tab_nxt = 1'b1;
            pos_nxt = '0;
            state_nxt = edf_pkg::ST_CH_IO;
          end
        end else if (!rd_pend_r) begin
          re = 1'b1;
          rd_pend_nxt = 1'b1;
        end else begin
          if (pos_r == '0) first_nxt = rd_id;
          if (later || pos_r + 1'b1 >= cnt_cur) begin
            if (tab_r) begin
              io_nxt = later ? rd_id : (pos_r == '0 ? rd_id : first_r);
              state_nxt = edf_pkg::ST_OUT;
            end else begin
              cpu_nxt = later ? rd_id : (pos_r == '0 ? rd_id : first_r);
              tab_nxt = 1'b1;
              pos_nxt = '0;
              state_nxt = edf_pkg::ST_CH_IO;
            end
          end else begin
            pos_nxt = pos_r + 1'b1;
            re = 1'b1;
            raddr = pos_nxt[AW-1:0];
            rd_pend_nxt = 1'b1;
          end
        end
      end

      edf_pkg::ST_OUT: begin
        if (!oval_r) begin
          oval_nxt = 1'b1;
          odata_nxt.cpu_choice = cpu_r;
          odata_nxt.io_choice = io_r;
          odata_nxt.table_overflow = drop_r;
          drop_nxt = 1'b0;
          tab_nxt = 1'b0;
          state_nxt = edf_pkg::ST_IDLE;
        end
      end

      default: state_nxt = edf_pkg::ST_IDLE;
    endcase
  end
endmodule

>>> src/edf_checker.sv
// Port-level checker for the scheduler, bound to the top level.
module edf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_cpu,
  input logic out_ovf
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cpu) && $stable(out_ovf))
    else $error("result changed while stalled");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind edf_cpu_io_scheduler_top edf_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_cpu(out_ch.data.cpu_choice), .out_ovf(out_ch.data.table_overflow)
);
